FILE: design/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and codes for the positional list store.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

	localparam int CMD_W = 3;
	localparam int POS_W = 6;
	localparam int VAL_W = 64;
	localparam int ST_W  = 2;
	localparam int CNT_W = 7;
	localparam int IDX_W = 6;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic                    first;
	} item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value_res;
		logic                    is_element;
		logic [ST_W-1:0]         status;
		logic [CNT_W-1:0]        count;
		logic                    last;
	} result_t;

	typedef struct packed {
		logic             exec;
		logic             emit;
		logic             last;
		logic [IDX_W-1:0] idx;
	} ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
	} stat_t;

endpackage

`default_nettype wire

FILE: design/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl
// Command sequencer: accepts commands and steps through a dump.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ctrl #(
	parameter int DEPTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire pls_pkg::item_t item,
	input  wire pls_pkg::stat_t stat,
	output logic                busy,
	output pls_pkg::ctl_t       ctl
);

	localparam int IW = $clog2(DEPTH);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic          state_q;
	logic [IW-1:0] idx_q;
	logic          accept;
	logic          dump_last;

	assign busy      = (state_q == S_DUMP);
	assign accept    = start && !busy;
	assign dump_last = ((pls_pkg::CNT_W'(idx_q) + pls_pkg::CNT_W'(1)) == stat.count);

	always_comb begin
		ctl      = '0;
		ctl.idx  = pls_pkg::IDX_W'(idx_q);
		ctl.last = dump_last;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (item.command inside {pls_pkg::CMD_LOAD, pls_pkg::CMD_DUMP,
						pls_pkg::CMD_INSERT, pls_pkg::CMD_UPDATE, pls_pkg::CMD_DELETE})) begin
					// empty dump answers with a single status reply
					ctl.exec = !((item.command == pls_pkg::CMD_DUMP) &&
						(stat.count != '0));
				end
			end
			S_DUMP: begin
				ctl.emit = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (item.command == pls_pkg::CMD_DUMP) &&
							(stat.count != '0)) begin
						state_q <= S_DUMP;
						idx_q   <= '0;
					end
				end
				S_DUMP: begin
					if (dump_last) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/pls_datapath.sv
// ----------------------------------------------------------------------------
// pls_datapath
// Element cells with parallel shift, element count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_datapath #(
	parameter int DEPTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pls_pkg::item_t item,
	input  wire pls_pkg::ctl_t  ctl,
	output pls_pkg::stat_t      stat,
	output logic                strobe,
	output pls_pkg::result_t    result
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int NW = pls_pkg::CNT_W;

	logic signed [pls_pkg::VAL_W-1:0] cells_q [DEPTH];
	logic signed [pls_pkg::VAL_W-1:0] up_w    [DEPTH];
	logic signed [pls_pkg::VAL_W-1:0] dn_w    [DEPTH];

	logic [CW-1:0]           cnt_q;
	logic                    strobe_q;
	pls_pkg::result_t        result_q;

	logic [NW-1:0]           cnt_x;
	logic [NW-1:0]           pos_x;
	logic [NW-1:0]           base_x;
	logic [NW-1:0]           ins_x;
	logic [NW-1:0]           cnt_n;
	logic                    full;
	logic                    in_range;
	logic                    wr_load;
	logic                    wr_ins;
	logic                    wr_upd;
	logic                    wr_del;
	logic [pls_pkg::ST_W-1:0] st;

	assign cnt_x    = NW'(cnt_q);
	assign pos_x    = NW'(item.position);
	assign base_x   = ((item.command == pls_pkg::CMD_LOAD) && item.first) ? '0 : cnt_x;
	assign full     = (base_x >= NW'(DEPTH));
	assign in_range = (pos_x < cnt_x);
	assign ins_x    = in_range ? pos_x : cnt_x;
	assign stat.count = cnt_x;

	always_comb begin
		wr_load = 1'b0;
		wr_ins  = 1'b0;
		wr_upd  = 1'b0;
		wr_del  = 1'b0;
		st      = pls_pkg::ST_OK;
		cnt_n   = cnt_x;
		unique case (item.command)
			pls_pkg::CMD_LOAD: begin
				if (full) begin
					st = pls_pkg::ST_FULL;
				end else begin
					wr_load = 1'b1;
					cnt_n   = base_x + NW'(1);
				end
			end
			pls_pkg::CMD_INSERT: begin
				if (full) begin
					st = pls_pkg::ST_FULL;
				end else begin
					wr_ins = 1'b1;
					cnt_n  = cnt_x + NW'(1);
				end
			end
			pls_pkg::CMD_UPDATE: begin
				if (in_range) begin
					wr_upd = 1'b1;
				end else begin
					st = pls_pkg::ST_INVALID;
				end
			end
			pls_pkg::CMD_DELETE: begin
				if (in_range) begin
					wr_del = 1'b1;
					cnt_n  = cnt_x - NW'(1);
				end else begin
					st = pls_pkg::ST_INVALID;
				end
			end
			default: begin
				st = pls_pkg::ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [NW-1:0] IX = NW'(i);

		if (i == 0) begin : g_first
			assign up_w[i] = cells_q[i];
		end else begin : g_up
			assign up_w[i] = cells_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign dn_w[i] = cells_q[i];
		end else begin : g_dn
			assign dn_w[i] = cells_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (ctl.exec) begin
				if (wr_load && (IX == base_x)) begin
					cells_q[i] <= item.value;
				end else if (wr_ins && (IX == ins_x)) begin
					cells_q[i] <= item.value;
				end else if (wr_ins && (IX > ins_x) && (IX <= cnt_x)) begin
					cells_q[i] <= up_w[i];
				end else if (wr_upd && (IX == pos_x)) begin
					cells_q[i] <= item.value;
				end else if (wr_del && (IX >= pos_x) && ((IX + NW'(1)) < cnt_x)) begin
					cells_q[i] <= dn_w[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.exec || ctl.emit;
			if (ctl.exec) begin
				cnt_q <= cnt_n[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			result_q.value_res  <= '0;
			result_q.is_element <= 1'b0;
			result_q.status     <= st;
			result_q.count      <= cnt_n;
			result_q.last       <= 1'b1;
		end else if (ctl.emit) begin
			result_q.value_res  <= cells_q[ctl.idx[IW-1:0]];
			result_q.is_element <= 1'b1;
			result_q.status     <= pls_pkg::ST_OK;
			result_q.count      <= cnt_x;
			result_q.last       <= ctl.last;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: design/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 64-bit values with load, dump, insert, update and
// delete at a position.
// ----------------------------------------------------------------------------
// A command transfer happens on a rising edge with start high and busy low.
// Load, insert, update and delete change the cells in that same edge
// unless refused; they and dump of an empty list give one status result
// on the next cycle; busy stays low, so these commands may follow every cycle.
// Dump of a non-empty list raises busy while a counter walks the cells,
// one element read per cycle; each result is registered and appears on the
// cycle after its read, the final one with last set, and the next command
// may be given in the cycle that shows it.
// Each result is held on result for one cycle, marked by strobe; there is
// no back-pressure, so the receiver must take it then.
// Insert and delete shift the cells from the position upward in parallel.
// Reset clears the count and the sequencer; cell contents stay undefined
// until written and no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
	parameter int DEPTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire pls_pkg::item_t item,
	output logic                busy,
	output logic                strobe,
	output pls_pkg::result_t    result
);

	pls_pkg::ctl_t  ctl;
	pls_pkg::stat_t stat;

	pls_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.stat  (stat),
		.busy  (busy),
		.ctl   (ctl)
	);

	pls_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.ctl   (ctl),
		.stat  (stat),
		.strobe(strobe),
		.result(result)
	);

endmodule

`default_nettype wire

FILE: design/pls_checker.sv
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks for the positional list store.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_checker #(
	parameter int DEPTH = 32
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             busy,
	input wire logic             strobe,
	input wire pls_pkg::result_t result
);

	// status replies always close a command
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.is_element |-> result.last)
		else $error("status reply without last");

	// elements carry ok status
	a_elem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.is_element |-> (result.status == pls_pkg::ST_OK))
		else $error("element with non-ok status");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.count <= pls_pkg::CNT_W'(DEPTH)))
		else $error("count beyond depth");

	// a dump runs without gaps until its last element
	a_dump_cont: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.is_element && !result.last |=> strobe && result.is_element)
		else $error("gap in dump transfer");

	// dump stays busy while elements remain
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.is_element && !result.last |-> busy)
		else $error("not busy during dump");

endmodule

bind positional_list_store pls_checker #(.DEPTH(DEPTH)) u_pls_checker (.*);

`default_nettype wire
